FILE: sv/block_sum_downsampler_unit_assert.svh
// Assertion macros for the checker file of this block.
`ifndef BLOCK_SUM_DOWNSAMPLER_UNIT_ASSERT_SVH
`define BLOCK_SUM_DOWNSAMPLER_UNIT_ASSERT_SVH

// Same-cycle implication, checked at the rising clock edge.
`define BSD_ASSERT_IMP(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked at the rising clock edge.
`define BSD_ASSERT_NXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: sv/bsd_pkg.sv
package bsd_pkg;

  localparam int SampleW = 16;
  localparam int SumW    = 22;
  localparam int ScaleW  = 4;
  localparam int WidthW  = 11;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 11;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [SumW-1:0]    sum_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SCALE_X      = 2'd0,
    CFG_SCALE_Y      = 2'd1,
    CFG_COARSE_WIDTH = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_t;

  localparam logic [ScaleW-1:0] ScaleXReset      = 4'd2;
  localparam logic [ScaleW-1:0] ScaleYReset      = 4'd2;
  localparam logic [WidthW-1:0] CoarseWidthReset = 11'd1024;

endpackage

FILE: sv/bsd_in_if.sv
interface bsd_in_if;
  logic              valid;
  logic              ready;
  bsd_pkg::sample_t  fine_sample;

  modport source (output valid, output fine_sample, input ready);
  modport sink   (input valid, input fine_sample, output ready);
endinterface

FILE: sv/bsd_out_if.sv
interface bsd_out_if;
  logic           valid;
  logic           ready;
  bsd_pkg::sum_t  cell_sum;

  modport source (output valid, output cell_sum, input ready);
  modport sink   (input valid, input cell_sum, output ready);
endinterface

FILE: sv/bsd_ram.sv
module bsd_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents when the same address is written in that cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/block_sum_downsampler_unit.sv
// Block sum downsampler (2-D sum pooling) over a raster stream.
// in_ch carries one signed Q8.8 fine sample per transaction, planes back to
// back in raster order. out_ch carries one signed Q14.8 cell sum per coarse
// cell, sent when the bottom-right sample of that cell has been accepted.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 scale_x,
// 1 scale_y, 2 coarse_width); write only while no transaction is in flight.
// Throughput is one sample per cycle while out_ch does not stall. The
// partial sums of the coarse row in progress live in a line store RAM with
// a registered read; a sample that ends a cell's row reads its column, and
// the next stage adds and writes back, or sends out on a cell's last row,
// with a forwarding register for a read and write of one column in the same cycle.
// A cell's sum passes through the s1 stage register and then the output
// register, which drives out_ch.valid and out_ch.cell_sum.
// Reset (rst_n low, synchronous) restores the default configuration and
// clears all counters and valid flags; the line store is not cleared.
// When out_ch stalls with a result pending, the whole pipeline holds and
// in_ch.ready goes low until the result is taken.
module block_sum_downsampler_unit #(
  parameter int MAX_COARSE_WIDTH = 1024,
  parameter int MAX_SCALE        = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  bsd_in_if.sink                         in_ch,
  bsd_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [bsd_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [bsd_pkg::CfgDataW-1:0]   cfg_data
);

  localparam int ColW = $clog2(MAX_COARSE_WIDTH);
  localparam int ScW  = $clog2(MAX_SCALE);

  typedef struct packed {
    logic            rd;
    logic            emit;
    logic [ColW-1:0] col;
    bsd_pkg::sum_t   acc;
  } stage_t;

  logic [bsd_pkg::ScaleW-1:0] scale_x_r, scale_y_r;
  logic [bsd_pkg::WidthW-1:0] coarse_width_r;

  logic [ScW:0]      sx, sy;
  logic [ColW:0]     cw;

  logic [ScW-1:0]    cic_r, ric_r;
  logic [ColW-1:0]   col_r;
  bsd_pkg::sum_t     cur_sum_r;

  logic              s1_valid_r;
  stage_t            s1_r;
  logic              fwd_valid_r;
  logic [ColW-1:0]   fwd_col_r;
  bsd_pkg::sum_t     fwd_data_r;
  logic              out_valid_r;
  bsd_pkg::sum_t     out_sum_r;

  logic              en, accept, cic_last, ric_last, col_last;
  bsd_pkg::sum_t     acc, prev, total, rdata;
  logic              ram_we;

  // Out-of-range register values act as the nearest legal value.
  assign sx = (scale_x_r == '0) ? (ScW+1)'(1) :
              (32'(scale_x_r) > MAX_SCALE) ? (ScW+1)'(MAX_SCALE) : (ScW+1)'(scale_x_r);
  assign sy = (scale_y_r == '0) ? (ScW+1)'(1) :
              (32'(scale_y_r) > MAX_SCALE) ? (ScW+1)'(MAX_SCALE) : (ScW+1)'(scale_y_r);
  assign cw = (coarse_width_r == '0) ? (ColW+1)'(1) :
              (32'(coarse_width_r) > MAX_COARSE_WIDTH) ? (ColW+1)'(MAX_COARSE_WIDTH) :
              (ColW+1)'(coarse_width_r);

  assign en     = !out_valid_r || out_ch.ready;
  assign accept = in_ch.valid && en;
  assign in_ch.ready = en;

  assign cic_last = ({1'b0, cic_r} + (ScW+1)'(1)) >= sx;
  assign ric_last = ({1'b0, ric_r} + (ScW+1)'(1)) >= sy;
  assign col_last = ({1'b0, col_r} + (ColW+1)'(1)) >= cw;
  assign acc      = cur_sum_r + bsd_pkg::sum_t'(in_ch.fine_sample);

  // The RAM misses a write made in the same cycle as its read; take it from here.
  assign prev   = (fwd_valid_r && (fwd_col_r == s1_r.col)) ? fwd_data_r : rdata;
  assign total  = s1_r.acc + (s1_r.rd ? prev : '0);
  assign ram_we = en && s1_valid_r && !s1_r.emit;

  bsd_ram #(
    .WIDTH (bsd_pkg::SumW),
    .DEPTH (MAX_COARSE_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_r.col),
    .wdata (total),
    .re    (accept && cic_last),
    .raddr (col_r),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_x_r      <= bsd_pkg::ScaleXReset;
      scale_y_r      <= bsd_pkg::ScaleYReset;
      coarse_width_r <= bsd_pkg::CoarseWidthReset;
    end else if (cfg_we) begin
      unique case (bsd_pkg::cfg_idx_t'(cfg_index))
        bsd_pkg::CFG_SCALE_X:      scale_x_r      <= cfg_data[bsd_pkg::ScaleW-1:0];
        bsd_pkg::CFG_SCALE_Y:      scale_y_r      <= cfg_data[bsd_pkg::ScaleW-1:0];
        bsd_pkg::CFG_COARSE_WIDTH: coarse_width_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cic_r     <= '0;
      ric_r     <= '0;
      col_r     <= '0;
      cur_sum_r <= '0;
    end else if (accept) begin
      if (!cic_last) begin
        cur_sum_r <= acc;
        cic_r     <= cic_r + ScW'(1);
      end else begin
        cur_sum_r <= '0;
        cic_r     <= '0;
        if (col_last) begin
          col_r <= '0;
          ric_r <= ric_last ? '0 : ric_r + ScW'(1);
        end else begin
          col_r <= col_r + ColW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= in_ch.valid && cic_last;
      fwd_valid_r <= ram_we;
      out_valid_r <= s1_valid_r && s1_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cic_last) begin
      s1_r.rd   <= (ric_r != '0);
      s1_r.emit <= ric_last;
      s1_r.col  <= col_r;
      s1_r.acc  <= acc;
    end
    if (en) begin
      fwd_col_r  <= s1_r.col;
      fwd_data_r <= total;
      out_sum_r  <= total;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.cell_sum = out_sum_r;

endmodule

FILE: sv/bsd_checker.sv
`include "block_sum_downsampler_unit_assert.svh"

module bsd_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input bsd_pkg::sum_t cell_sum
);

  `BSD_ASSERT_NXT(a_out_hold, clk, !rst_n, out_valid && !out_ready, out_valid && $stable(cell_sum))
  `BSD_ASSERT_IMP(a_stall_back, clk, !rst_n, out_valid && !out_ready, !in_ready)
  `BSD_ASSERT_IMP(a_ready_free, clk, !rst_n, !out_valid, in_ready)
  `BSD_ASSERT_NXT(a_reset_idle, clk, 1'b0, !rst_n, !out_valid)

endmodule

bind block_sum_downsampler_unit bsd_checker u_bsd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .cell_sum  (out_ch.cell_sum)
);
